/* hw/rtl/tpru_pkg.sv */
package tpru_pkg;

    // Parser phases; in PH_LOOKUP the stored mask is read from the mask RAM
    typedef enum logic [2:0]
    {
        PH_CHAN,
        PH_LOOKUP,
        PH_MASK,
        PH_NOTE,
        PH_INST,
        PH_VOL,
        PH_CMD,
        PH_PARAM
    } phase_t;

    // Commands held between parser and record stage
    localparam int QUEUE_DEPTH = 4;

    // Output tdata width: 71 bits of fields rounded up to whole bytes
    localparam int OUT_TDATA_W = 72;

    // One command from the parser: a finished channel entry or a row end
    typedef struct packed
    {
        logic        is_row_end;
        logic [5:0]  chan;
        logic        in_range;
        logic [7:0]  mask;
        logic [7:0]  note;
        logic [7:0]  inst;
        logic [7:0]  vol;
        logic [7:0]  cmd;
        logic [7:0]  param;
        logic [15:0] row_bits;
    } cmd_t;

    // One result item
    typedef struct packed
    {
        logic        is_row_end;
        logic [5:0]  chan_num;
        logic        in_range;
        logic [7:0]  note_val;
        logic [7:0]  instrument_num;
        logic [7:0]  volume_cmd;
        logic [7:0]  effect_cmd;
        logic [7:0]  effect_param;
        logic [3:0]  present_bits;
        logic [3:0]  active_flags;
        logic [15:0] row_channels;
    } result_t;

    // First selected field at or after field index 'from', else PH_CHAN
    function automatic phase_t next_field(input logic [3:0] sel, input logic [2:0] from);
        phase_t ph;
        if (from == 3'd0 && sel[0])
            ph = PH_NOTE;
        else if (from <= 3'd1 && sel[1])
            ph = PH_INST;
        else if (from <= 3'd2 && sel[2])
            ph = PH_VOL;
        else if (from <= 3'd3 && sel[3])
            ph = PH_CMD;
        else
            ph = PH_CHAN;
        return ph;
    endfunction

endpackage

/* hw/rtl/tpru_ram.sv */
module tpru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/tpru_front.sv */
module tpru_front #(
    parameter int CHANNELS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    output logic            push,
    output tpru_pkg::cmd_t  push_cmd,
    input  logic            q_space
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    tpru_pkg::phase_t phase_reg, phase_next;
    tpru_pkg::phase_t eff_phase, nf;
    logic [5:0]          chan_reg, chan_next;
    logic [7:0]          mask_reg, mask_next;
    logic [15:0]         row_reg, row_next;
    logic [CHANNELS-1:0] mvalid_reg, mvalid_next;
    logic [7:0]          note_reg, note_next;
    logic [7:0]          inst_reg, inst_next;
    logic [7:0]          vol_reg, vol_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic [7:0]          param_reg, param_next;

    logic          ok, new_ok, stall_emit, accept, is_end;
    logic [5:0]    new_chan;
    logic [7:0]    eff_mask, mask_rdata;
    logic          mask_we, rd_en;

    // Stored masks, one per channel
    tpru_ram #(
        .WIDTH (8),
        .DEPTH (CHANNELS)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (chan_reg[CW-1:0]),
        .wdata (in_byte),
        .re    (rd_en),
        .raddr (new_chan[CW-1:0]),
        .rdata (mask_rdata)
    );

    assign ok       = {1'b0, chan_reg} < 7'(CHANNELS);
    assign new_chan = 6'(in_byte - 8'd1);
    assign new_ok   = {1'b0, new_chan} < 7'(CHANNELS);

    // Resolve the mask: after a lookup it comes from the mask RAM
    always_comb
    begin
        if (phase_reg == tpru_pkg::PH_LOOKUP)
        begin
            eff_mask  = (ok && mvalid_reg[chan_reg[CW-1:0]]) ? mask_rdata : 8'h00;
            eff_phase = tpru_pkg::next_field(eff_mask[3:0], 3'd0);
        end
        else
        begin
            eff_mask  = mask_reg;
            eff_phase = phase_reg;
        end
    end

    // A looked-up mask with no fields completes the entry without a byte
    assign stall_emit = (phase_reg == tpru_pkg::PH_LOOKUP) && (eff_phase == tpru_pkg::PH_CHAN);
    assign in_ready   = q_space && !stall_emit;
    assign accept     = in_valid && in_ready;

    // Parse step
    always_comb
    begin
        phase_next  = phase_reg;
        chan_next   = chan_reg;
        mask_next   = eff_mask;
        row_next    = row_reg;
        mvalid_next = mvalid_reg;
        note_next   = note_reg;
        inst_next   = inst_reg;
        vol_next    = vol_reg;
        cmd_next    = cmd_reg;
        param_next  = param_reg;
        nf          = tpru_pkg::PH_CHAN;
        push        = 1'b0;
        is_end      = 1'b0;
        mask_we     = 1'b0;
        rd_en       = 1'b0;

        if (stall_emit)
        begin
            if (q_space)
            begin
                push       = 1'b1;
                phase_next = tpru_pkg::PH_CHAN;
            end
        end
        else if (accept)
        begin
            case (eff_phase)
                tpru_pkg::PH_MASK:
                begin
                    mask_next = in_byte;
                    mask_we   = ok;
                    if (ok)
                        mvalid_next[chan_reg[CW-1:0]] = 1'b1;
                    nf         = tpru_pkg::next_field(in_byte[3:0], 3'd0);
                    phase_next = nf;
                    push       = (nf == tpru_pkg::PH_CHAN);
                end
                tpru_pkg::PH_NOTE:
                begin
                    note_next  = in_byte;
                    nf         = tpru_pkg::next_field(eff_mask[3:0], 3'd1);
                    phase_next = nf;
                    push       = (nf == tpru_pkg::PH_CHAN);
                end
                tpru_pkg::PH_INST:
                begin
                    inst_next  = in_byte;
                    nf         = tpru_pkg::next_field(eff_mask[3:0], 3'd2);
                    phase_next = nf;
                    push       = (nf == tpru_pkg::PH_CHAN);
                end
                tpru_pkg::PH_VOL:
                begin
                    vol_next   = in_byte;
                    nf         = tpru_pkg::next_field(eff_mask[3:0], 3'd3);
                    phase_next = nf;
                    push       = (nf == tpru_pkg::PH_CHAN);
                end
                tpru_pkg::PH_CMD:
                begin
                    cmd_next   = in_byte;
                    phase_next = tpru_pkg::PH_PARAM;
                end
                tpru_pkg::PH_PARAM:
                begin
                    param_next = in_byte;
                    phase_next = tpru_pkg::PH_CHAN;
                    push       = 1'b1;
                end
                default:
                begin
                    // Channel byte, or zero for row end
                    phase_next = tpru_pkg::PH_CHAN;
                    if (in_byte == 8'h00)
                    begin
                        push     = 1'b1;
                        is_end   = 1'b1;
                        row_next = 16'h0000;
                    end
                    else
                    begin
                        chan_next = new_chan;
                        if (new_chan < 6'd16)
                            row_next = row_reg | (16'h0001 << new_chan[3:0]);
                        if (in_byte[7])
                            phase_next = tpru_pkg::PH_MASK;
                        else
                        begin
                            phase_next = tpru_pkg::PH_LOOKUP;
                            rd_en      = new_ok;
                        end
                    end
                end
            endcase
        end
    end

    // Command towards the record stage
    always_comb
    begin
        push_cmd.is_row_end = is_end;
        push_cmd.chan       = chan_reg;
        push_cmd.in_range   = ok;
        push_cmd.mask       = mask_next;
        push_cmd.note       = note_next;
        push_cmd.inst       = inst_next;
        push_cmd.vol        = vol_next;
        push_cmd.cmd        = cmd_next;
        push_cmd.param      = param_next;
        push_cmd.row_bits   = row_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tpru_pkg::PH_CHAN;
            chan_reg   <= '0;
            mask_reg   <= '0;
            row_reg    <= '0;
            mvalid_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            chan_reg   <= chan_next;
            mask_reg   <= mask_next;
            row_reg    <= row_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Field bytes of the entry in progress
    always_ff @(posedge clk)
    begin
        note_reg  <= note_next;
        inst_reg  <= inst_next;
        vol_reg   <= vol_next;
        cmd_reg   <= cmd_next;
        param_reg <= param_next;
    end

endmodule

/* hw/rtl/tpru_queue.sv */
module tpru_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tpru_pkg::cmd_t  push_cmd,
    output logic            space,
    input  logic            pop,
    output logic            head_valid,
    output tpru_pkg::cmd_t  head_cmd
);

    localparam int PW = $clog2(tpru_pkg::QUEUE_DEPTH);

    tpru_pkg::cmd_t entry_reg [tpru_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           do_push, do_pop;

    assign space      = count_reg != (PW + 1)'(tpru_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && space;
    assign do_pop     = pop && head_valid;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* hw/rtl/tpru_back.sv */
module tpru_back #(
    parameter int CHANNELS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tpru_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output tpru_pkg::result_t out_res
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CHANNELS-1:0] rvalid_reg, rvalid_next;
    tpru_pkg::cmd_t      b_cmd_reg;
    logic                b_hit_reg;
    logic                b_valid_reg, b_valid_next;
    tpru_pkg::result_t   out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic         out_load, entry_pop, rec_hit;
    logic [CW-1:0] idx;
    logic [4:0]   wr_sel, b_sel;
    logic [7:0]   fld_val   [5];
    logic [7:0]   fld_rdata [5];
    logic [7:0]   fld_out   [5];
    logic [4:0]   fld_we;

    assign idx       = head_cmd.chan[CW-1:0];
    assign out_load  = b_valid_reg && (!out_valid_reg || out_ready);
    assign pop       = head_valid && (!b_valid_reg || out_load);
    assign entry_pop = pop && !head_cmd.is_row_end && head_cmd.in_range;
    assign rec_hit   = head_cmd.in_range && rvalid_reg[idx];

    // Field order: note, instrument, volume, command, parameter
    assign wr_sel = {head_cmd.mask[3], head_cmd.mask[3], head_cmd.mask[2],
                     head_cmd.mask[1], head_cmd.mask[0]};
    assign fld_val[0] = head_cmd.note;
    assign fld_val[1] = head_cmd.inst;
    assign fld_val[2] = head_cmd.vol;
    assign fld_val[3] = head_cmd.cmd;
    assign fld_val[4] = head_cmd.param;

    // Record store; a channel never written is filled whole on first use
    for (genvar i = 0; i < 5; i++)
    begin : g_field
        assign fld_we[i] = entry_pop && (wr_sel[i] || !rec_hit);

        tpru_ram #(
            .WIDTH (8),
            .DEPTH (CHANNELS)
        ) u_field_ram (
            .clk   (clk),
            .we    (fld_we[i]),
            .waddr (idx),
            .wdata (wr_sel[i] ? fld_val[i] : 8'h00),
            .re    (pop),
            .raddr (idx),
            .rdata (fld_rdata[i])
        );
    end

    // Record valid bits
    always_comb
    begin
        rvalid_next = rvalid_reg;
        if (entry_pop)
            rvalid_next[idx] = 1'b1;
    end

    // Merge fresh bytes of the entry with the stored record
    assign b_sel = {b_cmd_reg.mask[3], b_cmd_reg.mask[3], b_cmd_reg.mask[2],
                    b_cmd_reg.mask[1], b_cmd_reg.mask[0]};

    always_comb
    begin
        fld_out[0] = b_cmd_reg.note;
        fld_out[1] = b_cmd_reg.inst;
        fld_out[2] = b_cmd_reg.vol;
        fld_out[3] = b_cmd_reg.cmd;
        fld_out[4] = b_cmd_reg.param;
        for (int i = 0; i < 5; i++)
        begin
            if (!b_sel[i])
                fld_out[i] = b_hit_reg ? fld_rdata[i] : 8'h00;
            if (!b_cmd_reg.in_range)
                fld_out[i] = 8'h00;
        end
    end

    // Result formatting
    always_comb
    begin
        if (b_cmd_reg.is_row_end)
        begin
            out_next              = '0;
            out_next.is_row_end   = 1'b1;
            out_next.row_channels = b_cmd_reg.row_bits;
        end
        else
        begin
            out_next.is_row_end     = 1'b0;
            out_next.chan_num       = b_cmd_reg.chan;
            out_next.in_range       = b_cmd_reg.in_range;
            out_next.note_val       = fld_out[0];
            out_next.instrument_num = fld_out[1];
            out_next.volume_cmd     = fld_out[2];
            out_next.effect_cmd     = fld_out[3];
            out_next.effect_param   = fld_out[4];
            out_next.present_bits   = b_cmd_reg.mask[3:0];
            out_next.active_flags   = b_cmd_reg.mask[7:4];
            out_next.row_channels   = 16'h0000;
        end
    end

    // Stage and output valids
    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (pop)
            b_valid_next = 1'b1;
        else if (out_load)
            b_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg    <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg    <= rvalid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_cmd_reg <= head_cmd;
            b_hit_reg <= rec_hit;
        end
        if (out_load)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

/* hw/rtl/tracker_pattern_row_unpacker.sv */
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata[7:0] = data_byte
// m_        out  m_tvalid/m_tready  m_tlast = is_row_end, m_tdata[71:0] = result fields
//
// One byte is taken per cycle while the command queue has space. A channel
// byte without its own mask starts a lookup in the mask RAM; if that mask
// selects no field bytes, input is held while the entry is queued. An entry
// leaving the queue passes the record RAM read and the output register.
// Reset is asynchronous; record and mask stores read as zero through valid
// bits. A four-deep command queue and the output register decouple stalls.
module tracker_pattern_row_unpacker #(
    parameter int CHANNELS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] data_byte
    input  logic [7:0]                       s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             m_tlast,
    // [5:0] chan_num, [6] in_range, [14:7] note_val, [22:15] instrument_num,
    // [30:23] volume_cmd, [38:31] effect_cmd, [46:39] effect_param,
    // [50:47] present_bits, [54:51] active_flags, [70:55] row_channels, [71] zero
    output logic [tpru_pkg::OUT_TDATA_W-1:0] m_tdata
);

    tpru_pkg::cmd_t    push_cmd, head_cmd;
    tpru_pkg::result_t res;
    logic              push, q_space, pop, head_valid;

    // Parser
    tpru_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd),
        .q_space  (q_space)
    );

    // Command queue
    tpru_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Record stage
    tpru_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    // Output packing
    assign m_tlast = res.is_row_end;
    assign m_tdata = {1'b0, res.row_channels, res.active_flags, res.present_bits,
                      res.effect_param, res.effect_cmd, res.volume_cmd,
                      res.instrument_num, res.note_val, res.in_range, res.chan_num};

endmodule
